@@ hw/rtl/srlh_pkg.sv @@
// shared constants, types and helpers of the two-state run-length histogram
// used by the histogram unit; no dependencies
package srlh_pkg;

   // histogram geometry
   localparam int BINS   = 1024;
   localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int CNT_W  = $clog2(BINS + 1);

   // field widths of the stream words
   localparam int BIN_W   = 10;
   localparam int LIFE_W  = 11;
   localparam int COUNT_W = 32;

   // result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // opcodes carried in tuser
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // sample classes
   localparam logic STATE_POLY = 1'b0;
   localparam logic STATE_ISO  = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // one result word
   typedef struct packed {
      logic [COUNT_W-1:0] poly_event_total;
      logic [COUNT_W-1:0] iso_event_total;
      logic [COUNT_W-1:0] poly_bin_count;
      logic [COUNT_W-1:0] iso_bin_count;
      logic [LIFE_W-1:0]  run_lifetime;
      logic               left_isolated;
      logic               transition_seen;
   } result_type;

   // saturating increment of a count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

endpackage

@@ hw/rtl/srlh_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read returns the contents before a same-cycle write
module srlh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/state_run_lifetime_histogram_unit.sv @@
// top level of the two-state run-length histogram
// depends on srlh_pkg and srlh_ram (one instance per histogram)
//
// Usage: words arrive on the req_ channel, one per cycle at most. tuser holds
// the opcode: a push carries one state sample (with a track-start flag), a
// read carries a bin number. Every accepted word yields exactly one result
// word on the rsp_ channel, in order: for a push the run that ended (if any),
// for a read both histogram counts at the bin; both event totals come with
// every result.
// Throughput is one word per cycle while req_tready is high: each histogram
// is one ram whose read is issued at accept and whose increment is written
// back the next cycle, with one-deep forwarding for back-to-back updates of the same bin.
// An accepted word is held in stage one, then written into the result queue.
// After reset the block sweeps both rams to zero, one bin per cycle, so
// req_tready stays low until the last bin is cleared.
// A stalled receiver fills a four-word result queue; outside the sweep, req_tready
// drops only when the queue and the word in flight would take its last slot.
module state_run_lifetime_histogram_unit (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // state_bit, track_start, bin_index[9:0], zero pad
   input  logic         req_tuser,   // opcode
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // transition_seen, left_isolated, run_lifetime[10:0],
                                     // iso_bin_count[31:0], poly_bin_count[31:0],
                                     // iso_event_total[31:0], poly_event_total[31:0], pad
);

   localparam int AW = srlh_pkg::ADDR_W;
   localparam int CW = srlh_pkg::CNT_W;
   localparam int NW = srlh_pkg::COUNT_W;
   localparam int PW = srlh_pkg::FIFO_PTR_W;
   localparam int QW = srlh_pkg::FIFO_CNT_W;

   // request fields
   logic                 req_fire;
   logic                 req_opcode;
   logic                 req_state_bit;
   logic                 req_track_start;
   logic [srlh_pkg::BIN_W-1:0] req_bin_index;

   assign req_opcode      = req_tuser;
   assign req_state_bit   = req_tdata[0];
   assign req_track_start = req_tdata[1];
   assign req_bin_index   = req_tdata[11:2];
   assign req_fire        = req_tvalid && req_tready;

   // run tracking and totals
   logic          held_ff, held_in;
   logic [CW-1:0] frames_ff, frames_in;
   logic [NW-1:0] iso_total_ff, iso_total_in;
   logic [NW-1:0] poly_total_ff, poly_total_in;

   // clearing sweep
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // stage one
   logic                         s1_valid_ff;
   logic                         s1_read_ff;
   logic                         s1_bin_ok_ff;
   logic                         s1_iso_upd_ff;
   logic                         s1_poly_upd_ff;
   logic [AW-1:0]                s1_addr_ff;
   logic                         s1_seen_ff;
   logic                         s1_left_ff;
   logic [srlh_pkg::LIFE_W-1:0]  s1_life_ff;
   logic [NW-1:0]                s1_iso_total_ff;
   logic [NW-1:0]                s1_poly_total_ff;

   // forwarding of the previous cycle's writes
   logic          fwd_iso_ff, fwd_poly_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [NW-1:0] fwd_iso_data_ff, fwd_poly_data_ff;

   // result queue
   srlh_pkg::result_type fifo_ff [srlh_pkg::FIFO_DEPTH];
   logic [PW-1:0]        fifo_wr_ptr_ff, fifo_rd_ptr_ff;
   logic [QW-1:0]        fifo_cnt_ff, fifo_cnt_in;
   logic [QW-1:0]        fifo_occ;
   logic                 fifo_push, fifo_pop;
   srlh_pkg::result_type s1_result;

   // ram ports
   logic          iso_we, poly_we;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [NW-1:0] iso_wdata, poly_wdata;
   logic [NW-1:0] iso_rdata, poly_rdata;

   // stage zero decode
   logic          push_op;
   logic [CW-1:0] frames_inc;
   logic          change;
   logic          counted;
   logic          iso_upd, poly_upd;
   logic          bin_ok;

   // stage one data
   logic [NW-1:0] iso_cur, poly_cur;
   logic [NW-1:0] iso_next, poly_next;
   logic          s1_iso_wr, s1_poly_wr;

   // accept rule: no sweep running and a queue slot left for the new word
   assign fifo_occ   = fifo_cnt_ff + QW'(s1_valid_ff);
   assign req_tready = !clr_busy_ff && (fifo_occ < QW'(srlh_pkg::FIFO_DEPTH));

   // run length and change detection
   always_comb begin
      push_op    = (req_opcode == srlh_pkg::OP_PUSH);
      frames_inc = (frames_ff < CW'(srlh_pkg::BINS)) ? frames_ff + CW'(1) : frames_ff;
      change     = push_op && !req_track_start && (req_state_bit != held_ff);
      counted    = change && (frames_inc < CW'(srlh_pkg::BINS));
      iso_upd    = counted && (held_ff == srlh_pkg::STATE_ISO);
      poly_upd   = counted && (held_ff == srlh_pkg::STATE_POLY);
      bin_ok     = (32'(req_bin_index) < srlh_pkg::BINS);
   end

   // next run state and totals
   always_comb begin
      held_in       = held_ff;
      frames_in     = frames_ff;
      iso_total_in  = iso_total_ff;
      poly_total_in = poly_total_ff;
      if (req_fire && push_op) begin
         if (req_track_start) begin
            held_in   = req_state_bit;
            frames_in = '0;
         end else if (change) begin
            held_in   = req_state_bit;
            frames_in = '0;
         end else begin
            frames_in = frames_inc;
         end
         if (iso_upd) begin
            iso_total_in = srlh_pkg::sat_inc(iso_total_ff);
         end
         if (poly_upd) begin
            poly_total_in = srlh_pkg::sat_inc(poly_total_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= srlh_pkg::STATE_POLY;
         frames_ff     <= '0;
         iso_total_ff  <= '0;
         poly_total_ff <= '0;
      end else begin
         held_ff       <= held_in;
         frames_ff     <= frames_in;
         iso_total_ff  <= iso_total_in;
         poly_total_ff <= poly_total_in;
      end
   end

   // ram read address: bin to read or lifetime to update
   assign ram_rd_addr = push_op ? AW'(frames_inc) : AW'(req_bin_index);

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      s1_read_ff       <= !push_op;
      s1_bin_ok_ff     <= bin_ok;
      s1_iso_upd_ff    <= iso_upd && req_fire;
      s1_poly_upd_ff   <= poly_upd && req_fire;
      s1_addr_ff       <= ram_rd_addr;
      s1_seen_ff       <= change;
      s1_left_ff       <= change && held_ff;
      s1_life_ff       <= change ? srlh_pkg::LIFE_W'(frames_inc) : '0;
      s1_iso_total_ff  <= iso_total_in;
      s1_poly_total_ff <= poly_total_in;
   end

   // read data with forwarding from the write of the previous cycle
   always_comb begin
      iso_cur    = (fwd_iso_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_iso_data_ff : iso_rdata;
      poly_cur   = (fwd_poly_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_poly_data_ff : poly_rdata;
      iso_next   = srlh_pkg::sat_inc(iso_cur);
      poly_next  = srlh_pkg::sat_inc(poly_cur);
      s1_iso_wr  = s1_valid_ff && s1_iso_upd_ff;
      s1_poly_wr = s1_valid_ff && s1_poly_upd_ff;
   end

   // write port: clearing sweep or stage one write-back
   always_comb begin
      if (clr_busy_ff) begin
         iso_we      = 1'b1;
         poly_we     = 1'b1;
         ram_wr_addr = clr_addr_ff;
         iso_wdata   = '0;
         poly_wdata  = '0;
      end else begin
         iso_we      = s1_iso_wr;
         poly_we     = s1_poly_wr;
         ram_wr_addr = s1_addr_ff;
         iso_wdata   = iso_next;
         poly_wdata  = poly_next;
      end
   end

   // forwarding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_iso_ff  <= 1'b0;
         fwd_poly_ff <= 1'b0;
      end else begin
         fwd_iso_ff  <= iso_we;
         fwd_poly_ff <= poly_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff      <= ram_wr_addr;
      fwd_iso_data_ff  <= iso_wdata;
      fwd_poly_data_ff <= poly_wdata;
   end

   // clearing sweep after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(srlh_pkg::BINS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // histogram memories
   srlh_ram #(
      .WIDTH (NW),
      .DEPTH (srlh_pkg::BINS)
   ) u_iso_ram (
      .clock   (clock),
      .wr_en   (iso_we),
      .wr_addr (ram_wr_addr),
      .wr_data (iso_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (iso_rdata)
   );

   srlh_ram #(
      .WIDTH (NW),
      .DEPTH (srlh_pkg::BINS)
   ) u_poly_ram (
      .clock   (clock),
      .wr_en   (poly_we),
      .wr_addr (ram_wr_addr),
      .wr_data (poly_wdata),
      .rd_addr (ram_rd_addr),
      .rd_data (poly_rdata)
   );

   // result word of stage one
   always_comb begin
      s1_result.transition_seen  = s1_seen_ff;
      s1_result.left_isolated    = s1_left_ff;
      s1_result.run_lifetime     = s1_life_ff;
      s1_result.iso_bin_count    = (s1_read_ff && s1_bin_ok_ff) ? iso_cur : '0;
      s1_result.poly_bin_count   = (s1_read_ff && s1_bin_ok_ff) ? poly_cur : '0;
      s1_result.iso_event_total  = s1_iso_total_ff;
      s1_result.poly_event_total = s1_poly_total_ff;
   end

   // result queue
   assign fifo_push = s1_valid_ff;
   assign fifo_pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (fifo_push && !fifo_pop) begin
         fifo_cnt_in = fifo_cnt_ff + QW'(1);
      end else if (!fifo_push && fifo_pop) begin
         fifo_cnt_in = fifo_cnt_ff - QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_cnt_ff    <= '0;
         fifo_wr_ptr_ff <= '0;
         fifo_rd_ptr_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (fifo_push) begin
            fifo_wr_ptr_ff <= fifo_wr_ptr_ff + PW'(1);
         end
         if (fifo_pop) begin
            fifo_rd_ptr_ff <= fifo_rd_ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[fifo_wr_ptr_ff] <= s1_result;
      end
   end

   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata  = {3'b000, fifo_ff[fifo_rd_ptr_ff]};

   // no word is taken while the sweep is still clearing the histograms
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !clr_busy_ff)
      else $error("word accepted during histogram clear");

   // the result queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= QW'(srlh_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // one run ends in one histogram only
   a_one_histogram: assert property (@(posedge clock) disable iff (reset)
      !(s1_iso_wr && s1_poly_wr))
      else $error("both histograms updated by one word");

   // every accepted word reaches the result queue on the next cycle
   a_word_advances: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (fifo_push && ($past(fifo_cnt_ff) != QW'(srlh_pkg::FIFO_DEPTH))))
      else $error("accepted word lost before the result queue");

endmodule
